@@ src/tbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants of the two-bit branch predictor.
// ---------------------------------------------------------------------------
package tbp_pkg;

   localparam int TABLE_ENTRIES_DEF = 1024;
   localparam int IDX_MAX_W         = 16;
   localparam int ADDR_W            = 32;
   localparam int COUNT_W           = 32;
   localparam int IDX_LSB           = 2;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [1:0] CNT_RESET     = 2'd2;
   localparam logic [1:0] CNT_TAKEN_MIN = 2'd2;
   localparam logic [1:0] CNT_MAX       = 2'd3;
   localparam logic [1:0] CNT_MIN       = 2'd0;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [ADDR_W-1:0] branch_address;
      logic [ADDR_W-1:0] next_address;
      logic [ADDR_W-1:0] target_address;
   } req_type;

   typedef struct packed {
      logic               predicted_taken;
      logic               was_taken;
      logic               prediction_correct;
      logic [COUNT_W-1:0] correct_total;
      logic [COUNT_W-1:0] branch_total;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      logic [IDX_MAX_W-1:0] index;
      logic                 taken;
   } queue_entry_type;

endpackage
`default_nettype wire

@@ src/tbp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_front
// Accepts branch items, resolves the outcome and reduces the word address
// to a table index, then hands the classified item to the queue.
// ---------------------------------------------------------------------------
module tbp_front #(
   parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       hold,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  tbp_pkg::req_type          req_data,
   output logic                      q_push,
   output tbp_pkg::queue_entry_type  q_data,
   input  wire                       q_full
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam bit POW2   = ((1 << IDX_W) == TABLE_ENTRIES);

   generate
      if (POW2) begin : g_mask
         logic                     valid_ff;
         logic                     valid_in;
         tbp_pkg::queue_entry_type entry_ff;
         logic                     accept;

         assign req_ready = !hold && (!valid_ff || !q_full);
         assign accept    = req_valid && req_ready;
         assign q_push    = valid_ff && !q_full;
         assign q_data    = entry_ff;
         assign valid_in  = accept || (valid_ff && q_full);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff <= 1'b0;
            end else begin
               valid_ff <= valid_in;
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               entry_ff.index <= tbp_pkg::IDX_MAX_W'(
                  req_data.branch_address[tbp_pkg::IDX_LSB +: IDX_W]);
               entry_ff.taken <= (req_data.next_address == req_data.target_address);
            end
         end
      end else begin : g_recip
         typedef enum logic [3:0] {
            ST_IDLE = 4'b0001,
            ST_MUL  = 4'b0010,
            ST_REM  = 4'b0100,
            ST_PUSH = 4'b1000
         } front_state_type;

         localparam int WORD_W = tbp_pkg::ADDR_W - tbp_pkg::IDX_LSB;
         localparam int R_W    = IDX_W + 1;
         localparam int PROD_W = 2 * WORD_W;
         // truncated reciprocal: the quotient estimate is at most one short
         localparam logic [63:0]       RECIP_FULL = (64'd1 << WORD_W) / 64'(TABLE_ENTRIES);
         localparam logic [WORD_W-1:0] RECIP      = RECIP_FULL[WORD_W-1:0];
         localparam logic [R_W-1:0]    DIVISOR    = R_W'(TABLE_ENTRIES);

         front_state_type   state_ff;
         front_state_type   state_in;
         logic [WORD_W-1:0] word_ff;
         logic              taken_ff;
         logic [R_W-1:0]    quot_ff;
         logic [R_W-1:0]    rem_ff;
         logic [R_W-1:0]    rem_in;
         logic [PROD_W-1:0] prod;
         logic [IDX_W-1:0]  rem_idx;
         logic              accept;

         assign req_ready = (state_ff == ST_IDLE) && !hold;
         assign accept    = req_valid && req_ready;
         assign q_push    = (state_ff == ST_PUSH) && !q_full;

         assign prod = PROD_W'(word_ff) * PROD_W'(RECIP);
         // raw remainder is below twice the divisor, so low bits suffice
         assign rem_in  = R_W'(word_ff[R_W-1:0] - R_W'(quot_ff * DIVISOR));
         assign rem_idx = (rem_ff >= DIVISOR) ? IDX_W'(rem_ff - DIVISOR) : IDX_W'(rem_ff);

         assign q_data.index = tbp_pkg::IDX_MAX_W'(rem_idx);
         assign q_data.taken = taken_ff;

         always_comb begin
            state_in = state_ff;
            unique case (state_ff)
               ST_IDLE: begin
                  if (accept) state_in = ST_MUL;
               end
               ST_MUL: begin
                  state_in = ST_REM;
               end
               ST_REM: begin
                  state_in = ST_PUSH;
               end
               ST_PUSH: begin
                  if (!q_full) state_in = ST_IDLE;
               end
               default: state_in = ST_IDLE;
            endcase
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               state_ff <= ST_IDLE;
            end else begin
               state_ff <= state_in;
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               word_ff  <= req_data.branch_address[tbp_pkg::ADDR_W-1:tbp_pkg::IDX_LSB];
               taken_ff <= (req_data.next_address == req_data.target_address);
            end
            if (state_ff == ST_MUL) quot_ff <= R_W'(prod >> WORD_W);
            if (state_ff == ST_REM) rem_ff  <= rem_in;
         end
      end
   endgenerate

endmodule
`default_nettype wire

@@ src/tbp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_queue
// Small queue of classified items between front and back.
// ---------------------------------------------------------------------------
module tbp_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  tbp_pkg::queue_entry_type  push_data,
   output logic                      full,
   input  wire                       pop,
   output tbp_pkg::queue_entry_type  pop_data,
   output logic                      not_empty
);

   localparam int DEPTH = tbp_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tbp_pkg::queue_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

@@ src/tbp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_back
// Counter table read-modify-write, running totals and the result register.
// ---------------------------------------------------------------------------
module tbp_back #(
   parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   output logic                      clearing,
   input  wire                       q_valid,
   output logic                      q_pop,
   input  tbp_pkg::queue_entry_type  q_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output tbp_pkg::rsp_type          rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int CW = tbp_pkg::COUNT_W;

   logic [1:0]       cnt_mem_ff [TABLE_ENTRIES];
   logic [1:0]       rd_ff;

   logic             clr_ff;
   logic [IDX_W-1:0] clr_idx_ff;

   logic             s2_valid_ff;
   logic             s2_valid_in;
   logic [IDX_W-1:0] s2_idx_ff;
   logic             s2_taken_ff;

   logic             fwd_valid_ff;
   logic [IDX_W-1:0] fwd_idx_ff;
   logic [1:0]       fwd_cnt_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   tbp_pkg::rsp_type rsp_data_ff;
   logic [CW-1:0]    correct_ff;
   logic [CW-1:0]    correct_in;
   logic [CW-1:0]    total_ff;
   logic [CW-1:0]    total_in;

   logic             commit;
   logic [1:0]       cur_cnt;
   logic [1:0]       new_cnt;
   logic             pred;
   logic             ok;
   logic [IDX_W-1:0] q_idx;

   assign clearing  = clr_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign commit = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign q_pop  = q_valid && !clr_ff && (!s2_valid_ff || commit);
   assign q_idx  = q_data.index[IDX_W-1:0];

   // the read at pop time misses a write to the same entry on that same edge
   assign cur_cnt = (fwd_valid_ff && (fwd_idx_ff == s2_idx_ff)) ? fwd_cnt_ff : rd_ff;
   assign pred    = (cur_cnt >= tbp_pkg::CNT_TAKEN_MIN);
   assign ok      = (pred == s2_taken_ff);

   always_comb begin
      new_cnt = cur_cnt;
      if (s2_taken_ff) begin
         if (cur_cnt != tbp_pkg::CNT_MAX) new_cnt = cur_cnt + 2'd1;
      end else begin
         if (cur_cnt != tbp_pkg::CNT_MIN) new_cnt = cur_cnt - 2'd1;
      end
   end

   always_comb begin
      correct_in = correct_ff;
      total_in   = total_ff;
      if (commit) begin
         if (ok && (correct_ff != tbp_pkg::COUNT_MAX)) correct_in = correct_ff + CW'(1);
         if (total_ff != tbp_pkg::COUNT_MAX)           total_in   = total_ff + CW'(1);
      end
   end

   assign s2_valid_in  = q_pop || (s2_valid_ff && !commit);
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         correct_ff   <= '0;
         total_ff     <= '0;
      end else begin
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == LAST_IDX) clr_ff <= 1'b0;
         end
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         correct_ff   <= correct_in;
         total_ff     <= total_in;
         if (commit) fwd_valid_ff <= 1'b1;
      end
   end

   // counter table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         cnt_mem_ff[clr_idx_ff] <= tbp_pkg::CNT_RESET;
      end else if (commit) begin
         cnt_mem_ff[s2_idx_ff] <= new_cnt;
      end
      if (q_pop) rd_ff <= cnt_mem_ff[q_idx];
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s2_idx_ff   <= q_idx;
         s2_taken_ff <= q_data.taken;
      end
      if (commit) begin
         fwd_idx_ff                     <= s2_idx_ff;
         fwd_cnt_ff                     <= new_cnt;
         rsp_data_ff.predicted_taken    <= pred;
         rsp_data_ff.was_taken          <= s2_taken_ff;
         rsp_data_ff.prediction_correct <= ok;
         rsp_data_ff.correct_total      <= correct_in;
         rsp_data_ff.branch_total       <= total_in;
      end
   end

endmodule
`default_nettype wire

@@ src/two_bit_branch_predictor_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// two_bit_branch_predictor_top
// Bimodal predictor with a table of 2-bit saturating counters.
// ---------------------------------------------------------------------------
// Each accepted item is one resolved branch; exactly one result item follows
// with the prediction made before the update, the actual outcome, whether
// they agree, and saturating totals of correct and all branches. After reset
// the counter table is cleared to weakly taken in one pass over all entries,
// during which req_ready stays low. With a power-of-two TABLE_ENTRIES the
// index is a bit slice and the block takes one item per cycle while the
// queue has room; each item passes the front register, the queue, the table
// read stage and the result register. Any other size reduces the word address
// by a reciprocal multiply and a correction step in the front, so the front
// takes a new item only after its multiply, remainder and push states. The
// back end sustains one item per cycle while results are taken, through its
// single table read port and write port, forwarding back-to-back updates of
// one entry; a stalled result fills the queue and then holds req_ready low.
module two_bit_branch_predictor_top #(
   parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  tbp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output tbp_pkg::rsp_type  rsp_data
);

   logic                     clearing;
   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_not_empty;
   tbp_pkg::queue_entry_type q_push_data;
   tbp_pkg::queue_entry_type q_pop_data;

   tbp_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .q_full    (q_full)
   );

   tbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   tbp_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .q_valid   (q_not_empty),
      .q_pop     (q_pop),
      .q_data    (q_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ src/tbp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the branch predictor, bound to the top level.
// ---------------------------------------------------------------------------
module tbp_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input tbp_pkg::rsp_type rsp_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_correct_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.prediction_correct ==
                    (rsp_data.predicted_taken == rsp_data.was_taken))
      else $error("correct flag disagrees with prediction and outcome");

   a_totals_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.correct_total <= rsp_data.branch_total)
      else $error("correct total exceeds branch total");

   // no item may be taken in right after reset, when the table clearing begins
   a_no_accept_after_reset: assert property (@(posedge clock)
      reset |=> !(req_valid && req_ready))
      else $error("item accepted during table clear");

endmodule

bind two_bit_branch_predictor_top tbp_checker u_tbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
